FILE: src/pbf_pkg.sv
// Shared types and constants for the partitioned bloom filter.
// No dependencies; imported by pbf_mod_lane and partitioned_bloom_filter.
`default_nettype none

package pbf_pkg;

    // key digest and divide loop
    localparam int DIGEST_W = 64;
    localparam int CNT_W    = 6;

    // filter size register and remainder width
    localparam int SIZE_W   = 13;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 2'd1;

    // reset values of the configuration registers
    localparam logic              INDEX_MODE_RESET  = 1'b1;
    localparam logic [SIZE_W-1:0] FILTER_SIZE_RESET = 13'd4096;

    // request operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // index mode codes
    localparam logic MODE_INDEPENDENT = 1'b0;
    localparam logic MODE_DOUBLE_HASH = 1'b1;

    // control from the sequencer to the remainder lanes
    typedef struct packed {
        logic load;
        logic step;
    } pbf_lane_ctl_t;

endpackage

`default_nettype wire

FILE: src/pbf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module pbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/pbf_mod_lane.sv
// Remainder lane: 64-bit dividend mod 13-bit size, one bit per cycle in ctl.step.
// Depends on pbf_pkg for widths and the lane control struct.
`default_nettype none

module pbf_mod_lane
    import pbf_pkg::*;
(
    input  wire logic                clk,
    input  wire pbf_lane_ctl_t       ctl,
    input  wire logic [DIGEST_W-1:0] dividend,
    input  wire logic [SIZE_W-1:0]   size,
    output logic      [SIZE_W-1:0]   rem
);

    logic [DIGEST_W-1:0] dvd_reg;
    logic [DIGEST_W-1:0] dvd_next;
    logic [SIZE_W-1:0]   rem_reg;
    logic [SIZE_W-1:0]   rem_next;
    logic [SIZE_W:0]     trial;

    // restoring step: shift in the next dividend bit, subtract size if it fits
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIGEST_W-1]};
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        if (ctl.load)
        begin
            dvd_next = dividend;
            rem_next = '0;
        end
        else if (ctl.step)
        begin
            if (trial >= {1'b0, size})
            begin
                trial = trial - {1'b0, size};
            end
            rem_next = trial[SIZE_W-1:0];
            dvd_next = {dvd_reg[DIGEST_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign rem = rem_reg;

endmodule

`default_nettype wire

FILE: src/partitioned_bloom_filter.sv
// Partitioned bloom filter: NUM_UNITS bit arrays in one byte-wide RAM.
// Requests arrive on in_valid/in_stall with an operation and seven key digests;
// an insert sets one bit per unit and gives no result, a query gives one hit
// flag on out_valid/out_stall, high only if every unit's indexed bit is set.
// Configuration (index_mode, filter_size) is written through cfg_we/cfg_index/
// cfg_data; the user writes it only while the block is idle, which the block
// itself does not enforce. Writes to other indexes are ignored. After reset a
// clearing pass zeroes the store, one byte row per cycle, with in_stall high.
// A query runs the bit-serial remainder lanes, one per unit in parallel, then
// a read and a modify/check step per unit on the one RAM, and then loads the
// result register; an insert ends after its last modify step.
// One request is in work at a time. A query result sits in an output register;
// the next request is taken while it waits, but a following query holds at
// its end until out_stall lets the previous result go.
// Reset clears control state and sets index_mode to double hashing and
// filter_size to 4096.
`default_nettype none

module partitioned_bloom_filter
    import pbf_pkg::*;
#(
    parameter int NUM_UNITS = 7,
    parameter int UNIT_BITS = 4096
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  operation,
    input  wire logic [DIGEST_W-1:0]   digest_0,
    input  wire logic [DIGEST_W-1:0]   digest_1,
    input  wire logic [DIGEST_W-1:0]   digest_2,
    input  wire logic [DIGEST_W-1:0]   digest_3,
    input  wire logic [DIGEST_W-1:0]   digest_4,
    input  wire logic [DIGEST_W-1:0]   digest_5,
    input  wire logic [DIGEST_W-1:0]   digest_6,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       hit
);

    localparam int TOTAL_BITS = NUM_UNITS * UNIT_BITS;
    localparam int ROWS       = (TOTAL_BITS + 7) / 8;
    localparam int POS_W      = ($clog2(TOTAL_BITS) > 4) ? $clog2(TOTAL_BITS) : 4;
    localparam int RA_W       = POS_W - 3;
    localparam int UNIT_W     = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int NUM_DIGEST = 7;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_READ   = 6'b001000,
        ST_MODIFY = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                index_mode_reg;
    logic [SIZE_W-1:0]   filter_size_reg;
    logic [SIZE_W-1:0]   eff_size;
    logic [RA_W-1:0]     clr_reg;
    logic [RA_W-1:0]     clr_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [UNIT_W-1:0]   unit_reg;
    logic [UNIT_W-1:0]   unit_next;
    logic [POS_W-1:0]    base_reg;
    logic [POS_W-1:0]    base_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                query_reg;
    logic                query_next;
    logic                acc_reg;
    logic                acc_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                hit_reg;
    logic                hit_next;
    logic                in_accept;
    logic                last_unit;
    pbf_lane_ctl_t       lane_ctl;
    logic [DIGEST_W-1:0] digest [NUM_DIGEST];
    logic [SIZE_W-1:0]   lane_rem [NUM_UNITS];
    logic                ram_we;
    logic [RA_W-1:0]     ram_waddr;
    logic [7:0]          ram_wdata;
    logic [RA_W-1:0]     ram_raddr;
    logic [7:0]          ram_rdata;
    logic [7:0]          bit_mask;

    // small constant times a digest as shifts and adds, wrapping at 64 bits
    function automatic logic [DIGEST_W-1:0] times_small(
        input logic [DIGEST_W-1:0] x,
        input logic [2:0]          k
    );
        logic [DIGEST_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < 3; b++)
        begin
            if (k[b])
            begin
                acc = acc + (x << b);
            end
        end
        return acc;
    endfunction

    assign digest[0] = digest_0;
    assign digest[1] = digest_1;
    assign digest[2] = digest_2;
    assign digest[3] = digest_3;
    assign digest[4] = digest_4;
    assign digest[5] = digest_5;
    assign digest[6] = digest_6;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_mode_reg  <= INDEX_MODE_RESET;
            filter_size_reg <= FILTER_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INDEX_MODE:  index_mode_reg  <= cfg_data[0];
                REG_FILTER_SIZE: filter_size_reg <= cfg_data[SIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    // effective modulus: zero reads as one, saturate at the unit size
    always_comb
    begin
        eff_size = filter_size_reg;
        if (filter_size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (32'(filter_size_reg) > 32'(UNIT_BITS))
        begin
            eff_size = SIZE_W'(UNIT_BITS);
        end
    end

    assign in_accept      = in_valid && !in_stall;
    assign in_stall       = (state_reg != ST_IDLE);
    assign lane_ctl.load  = in_accept;
    assign lane_ctl.step  = (state_reg == ST_DIV);

    // one remainder lane per unit, dividend picked by index mode
    for (genvar j = 0; j < NUM_UNITS; j++)
    begin : g_lane
        logic [DIGEST_W-1:0] dividend;

        always_comb
        begin
            if (index_mode_reg == MODE_DOUBLE_HASH)
            begin
                dividend = digest_0 + times_small(digest_1, 3'(j));
            end
            else
            begin
                dividend = digest[j];
            end
        end

        pbf_mod_lane u_lane (
            .clk      (clk),
            .ctl      (lane_ctl),
            .dividend (dividend),
            .size     (eff_size),
            .rem      (lane_rem[j])
        );
    end

    assign last_unit = (unit_reg == UNIT_W'(NUM_UNITS - 1));
    assign bit_mask  = 8'(1) << pos_reg[2:0];

    // sequencer: clear, divide, read and modify one unit at a time, load a query result
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        unit_next      = unit_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        query_next     = query_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg[POS_W-1:3];
        ram_wdata      = ram_rdata | bit_mask;
        ram_raddr      = pos_reg[POS_W-1:3];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == RA_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + RA_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    query_next = (operation == OP_QUERY);
                    acc_next   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIGEST_W - 1))
                begin
                    unit_next  = '0;
                    base_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                pos_next   = base_reg + POS_W'(lane_rem[unit_reg]);
                ram_raddr  = pos_next[POS_W-1:3];
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (query_reg)
                begin
                    if ((ram_rdata & bit_mask) == '0)
                    begin
                        acc_next = 1'b0;
                    end
                end
                else
                begin
                    ram_we = 1'b1;
                end
                unit_next = unit_reg + UNIT_W'(1);
                base_next = base_reg + POS_W'(UNIT_BITS);
                if (!last_unit)
                begin
                    state_next = ST_READ;
                end
                else if (query_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            unit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            unit_reg      <= unit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        pos_reg   <= pos_next;
        query_reg <= query_next;
        acc_reg   <= acc_next;
        hit_reg   <= hit_next;
    end

    // bit store, one byte per row
    pbf_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

endmodule

`default_nettype wire
